FILE: design/field_to_radix_limbs_unit_assert.svh
// Assertion macros for the field to radix limbs unit.
// Used by the top level; expects clock and reset in scope.
`ifndef FIELD_TO_RADIX_LIMBS_UNIT_ASSERT_SVH
`define FIELD_TO_RADIX_LIMBS_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define F2RL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("f2rl same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define F2RL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("f2rl next-cycle check failed");

`endif

FILE: design/f2rl_pkg.sv
// Shared types and constants for the field to radix limbs unit.
// No dependencies; used by f2rl_ctrl, f2rl_datapath and the top level.
`default_nettype none

package f2rl_pkg;

   // value is held as 32 bytes, most significant byte 6 bits wide
   localparam int VAL_BYTES = 32;

   localparam logic [31:0] RADIX_MIN = 32'd2;
   localparam logic [31:0] RADIX_MAX = 32'd256;

   localparam logic [2:0] ERR_OK         = 3'd0;
   localparam logic [2:0] ERR_ADDR       = 3'd1;
   localparam logic [2:0] ERR_RADIX      = 3'd2;
   localparam logic [2:0] ERR_BITS       = 3'd3;
   localparam logic [2:0] ERR_ZERO_COUNT = 3'd4;
   localparam logic [2:0] ERR_COUNT      = 3'd5;

   typedef struct packed {
      logic load;         // capture request fields
      logic init_div;     // start the first division pass
      logic div_step;     // one byte of long division
      logic init_emit;    // set up the limb readout
      logic prime;        // first buffer read in flight
      logic emit_step;    // one limb into the packer
      logic emit_single;  // lone error or empty result
   } f2rl_cmd_type;

   typedef struct packed {
      logic [2:0] err;
      logic       count_zero;
      logic       pass_end;
      logic       limbs_done;
      logic       emit_last;
   } f2rl_sts_type;

endpackage

`default_nettype wire

FILE: design/f2rl_ctrl.sv
// Sequencer for the field to radix limbs unit.
// Depends on f2rl_pkg for command and status types.
`default_nettype none

module f2rl_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire f2rl_pkg::f2rl_sts_type sts,
   output f2rl_pkg::f2rl_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_PRIME = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((sts.err != f2rl_pkg::ERR_OK) || sts.count_zero) begin
               cmd.emit_single = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd.init_div = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.pass_end && sts.limbs_done) begin
               cmd.init_emit = 1'b1;
               state_in      = ST_PRIME;
            end
         end
         ST_PRIME: begin
            cmd.prime = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_step = 1'b1;
            if (sts.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

FILE: design/f2rl_datapath.sv
// Datapath of the field to radix limbs unit: request registers, checks,
// byte-serial divider, limb buffer and result packer. Depends on f2rl_pkg.
`default_nettype none

module f2rl_datapath #(
   parameter int MAX_LIMBS        = 256,
   parameter int LIMBS_PER_RESULT = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire f2rl_pkg::f2rl_cmd_type cmd,
   output f2rl_pkg::f2rl_sts_type      sts,
   input  wire logic [31:0]            highest_address,
   input  wire logic [63:0]            req_value_w0,
   input  wire logic [63:0]            req_value_w1,
   input  wire logic [63:0]            req_value_w2,
   input  wire logic [61:0]            req_value_w3,
   input  wire logic [31:0]            req_radix,
   input  wire logic [31:0]            req_limb_count,
   input  wire logic                   req_bits_mode,
   input  wire logic [31:0]            req_dest_address,
   output logic                        rsp_valid,
   output logic [31:0]                 rsp_write_address,
   output logic [63:0]                 rsp_limbs_packed,
   output logic [3:0]                  rsp_limb_count_here,
   output logic                        rsp_bit_tagged,
   output logic [2:0]                  rsp_error_cause,
   output logic                        rsp_last
);

   localparam int LIDX_W = $clog2(MAX_LIMBS);
   localparam int CNT_W  = $clog2(MAX_LIMBS + 1);
   localparam int KW     = (LIMBS_PER_RESULT > 1) ? $clog2(LIMBS_PER_RESULT) : 1;
   localparam int BW     = $clog2(f2rl_pkg::VAL_BYTES);

   // one step of long division: {rem, din} / d, with rem < d <= 256
   function automatic logic [15:0] div_byte(input logic [7:0] rem, input logic [7:0] din,
                                            input logic [8:0] d);
      logic [8:0] r;
      logic [8:0] t;
      logic [7:0] q;
      r = {1'b0, rem};
      q = '0;
      for (int i = 7; i >= 0; i--) begin
         t = {r[7:0], din[i]};
         if (t >= d) begin
            r    = t - d;
            q[i] = 1'b1;
         end else begin
            r = t;
         end
      end
      return {q, r[7:0]};
   endfunction

   // request
   logic [f2rl_pkg::VAL_BYTES-1:0][7:0] val_ff, val_in;
   logic [31:0] radix_ff, count_ff, dest_ff;
   logic        bits_ff;

   // division
   logic [BW-1:0]     byte_idx_ff, byte_idx_in;
   logic [BW-1:0]     top_ff, top_in;
   logic [7:0]        rem_ff, rem_in;
   logic [LIDX_W-1:0] limb_idx_ff, limb_idx_in;
   logic [LIDX_W-1:0] cnt_m1;
   logic [15:0]       qr;
   logic [7:0]        quo, rmd;

   // limb buffer and readout
   logic [7:0]        limb_mem [MAX_LIMBS];
   logic [7:0]        rd_data_ff;
   logic [LIDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  emit_left_ff, emit_left_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [63:0]       acc_ff, acc_in, packed_next;
   logic [31:0]       chunk_addr_ff, chunk_addr_in;
   logic              chunk_end;

   // result registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [63:0] rsp_packed_ff, rsp_packed_in;
   logic [3:0]  rsp_cnt_ff, rsp_cnt_in;
   logic        rsp_tag_ff, rsp_tag_in;
   logic [2:0]  rsp_err_ff, rsp_err_in;
   logic        rsp_last_ff, rsp_last_in;

   // parameter checks, in priority order
   logic [32:0] end_sum, addr_lim;
   logic        nonzero;
   logic [2:0]  err;

   always_comb begin
      end_sum  = {1'b0, dest_ff} + {1'b0, count_ff};
      addr_lim = {1'b0, highest_address} + 33'd1;
      nonzero  = |val_ff;
      if ((end_sum == '0) || (end_sum > addr_lim)) begin
         err = f2rl_pkg::ERR_ADDR;
      end else if ((radix_ff < f2rl_pkg::RADIX_MIN) || (radix_ff > f2rl_pkg::RADIX_MAX)) begin
         err = f2rl_pkg::ERR_RADIX;
      end else if (bits_ff && (radix_ff != f2rl_pkg::RADIX_MIN)) begin
         err = f2rl_pkg::ERR_BITS;
      end else if ((count_ff == '0) && nonzero) begin
         err = f2rl_pkg::ERR_ZERO_COUNT;
      end else if (count_ff > 32'(MAX_LIMBS)) begin
         err = f2rl_pkg::ERR_COUNT;
      end else begin
         err = f2rl_pkg::ERR_OK;
      end
   end

   assign cnt_m1    = LIDX_W'(count_ff - 32'd1);
   assign qr        = div_byte(rem_ff, val_ff[byte_idx_ff], radix_ff[8:0]);
   assign quo       = qr[15:8];
   assign rmd       = qr[7:0];

   assign packed_next = acc_ff | (64'(rd_data_ff) << {k_ff, 3'b000});
   assign chunk_end   = (k_ff == KW'(LIMBS_PER_RESULT - 1)) || (emit_left_ff == CNT_W'(1));

   assign sts.err        = err;
   assign sts.count_zero = (count_ff == '0);
   assign sts.pass_end   = (byte_idx_ff == '0);
   assign sts.limbs_done = (limb_idx_ff == cnt_m1);
   assign sts.emit_last  = (emit_left_ff == CNT_W'(1));

   always_comb begin
      val_in        = val_ff;
      byte_idx_in   = byte_idx_ff;
      top_in        = top_ff;
      rem_in        = rem_ff;
      limb_idx_in   = limb_idx_ff;
      rd_ptr_in     = rd_ptr_ff;
      emit_left_in  = emit_left_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      chunk_addr_in = chunk_addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_packed_in = rsp_packed_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.load) begin
         val_in = {2'b00, req_value_w3, req_value_w2, req_value_w1, req_value_w0};
      end

      if (cmd.init_div) begin
         byte_idx_in = BW'(f2rl_pkg::VAL_BYTES - 1);
         top_in      = BW'(f2rl_pkg::VAL_BYTES - 1);
         rem_in      = '0;
         limb_idx_in = '0;
      end

      if (cmd.div_step) begin
         val_in[byte_idx_ff] = quo;
         // drop the leading byte from later passes once it is zero
         if ((byte_idx_ff == top_ff) && (quo == '0) && (top_ff != '0)) begin
            top_in = top_ff - BW'(1);
         end
         if (byte_idx_ff == '0) begin
            rem_in      = '0;
            limb_idx_in = limb_idx_ff + LIDX_W'(1);
            byte_idx_in = top_in;
         end else begin
            rem_in      = rmd;
            byte_idx_in = byte_idx_ff - BW'(1);
         end
      end

      if (cmd.init_emit) begin
         rd_ptr_in     = cnt_m1;
         emit_left_in  = CNT_W'(count_ff);
         k_in          = '0;
         acc_in        = '0;
         chunk_addr_in = dest_ff;
      end

      if (cmd.prime) begin
         rd_ptr_in = rd_ptr_ff - LIDX_W'(1);
      end

      if (cmd.emit_step) begin
         rd_ptr_in    = rd_ptr_ff - LIDX_W'(1);
         emit_left_in = emit_left_ff - CNT_W'(1);
         if (chunk_end) begin
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = chunk_addr_ff;
            rsp_packed_in = packed_next;
            rsp_cnt_in    = 4'(k_ff) + 4'd1;
            rsp_tag_in    = bits_ff;
            rsp_err_in    = f2rl_pkg::ERR_OK;
            rsp_last_in   = (emit_left_ff == CNT_W'(1));
            acc_in        = '0;
            k_in          = '0;
            chunk_addr_in = chunk_addr_ff + 32'(LIMBS_PER_RESULT);
         end else begin
            acc_in = packed_next;
            k_in   = k_ff + KW'(1);
         end
      end

      if (cmd.emit_single) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = dest_ff;
         rsp_packed_in = '0;
         rsp_cnt_in    = '0;
         rsp_tag_in    = (err == f2rl_pkg::ERR_OK) ? bits_ff : 1'b0;
         rsp_err_in    = err;
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         radix_ff <= req_radix;
         count_ff <= req_limb_count;
         bits_ff  <= req_bits_mode;
         dest_ff  <= req_dest_address;
      end
      val_ff        <= val_in;
      byte_idx_ff   <= byte_idx_in;
      top_ff        <= top_in;
      rem_ff        <= rem_in;
      limb_idx_ff   <= limb_idx_in;
      rd_ptr_ff     <= rd_ptr_in;
      emit_left_ff  <= emit_left_in;
      k_ff          <= k_in;
      acc_ff        <= acc_in;
      chunk_addr_ff <= chunk_addr_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_packed_ff <= rsp_packed_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // limb buffer: little-endian limbs, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.div_step && (byte_idx_ff == '0)) begin
         limb_mem[limb_idx_ff] <= rmd;
      end
      rd_data_ff <= limb_mem[rd_ptr_ff];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_write_address   = rsp_addr_ff;
   assign rsp_limbs_packed    = rsp_packed_ff;
   assign rsp_limb_count_here = rsp_cnt_ff;
   assign rsp_bit_tagged      = rsp_tag_ff;
   assign rsp_error_cause     = rsp_err_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

`default_nettype wire

FILE: design/field_to_radix_limbs_unit.sv
// An error or empty request is caught in the check state, which loads its one beat into the result registers.
// A conversion runs one divide pass per limb, byte by byte from the current top byte down
// (32 bytes on the first pass, one fewer after a pass whose top byte comes out zero), then
// primes the limb buffer read and reads out one limb per cycle into the packer.
// Throughput: one request at a time; the next start is taken while the last beat is shown.
// Reset clears the sequencer and result strobe; highest_address resets to all ones.
`default_nettype none

module field_to_radix_limbs_unit #(
   parameter int MAX_LIMBS        = 256,
   parameter int LIMBS_PER_RESULT = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_value_w0,
   input  wire logic [63:0] req_value_w1,
   input  wire logic [63:0] req_value_w2,
   input  wire logic [61:0] req_value_w3,
   input  wire logic [31:0] req_radix,
   input  wire logic [31:0] req_limb_count,
   input  wire logic        req_bits_mode,
   input  wire logic [31:0] req_dest_address,
   // result channel
   output logic             rsp_valid,
   output logic [31:0]      rsp_write_address,
   output logic [63:0]      rsp_limbs_packed,
   output logic [3:0]       rsp_limb_count_here,
   output logic             rsp_bit_tagged,
   output logic [2:0]       rsp_error_cause,
   output logic             rsp_last,
   // configuration
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data
);

   // highest writable address, used by the range check
   logic [31:0] highest_addr_ff;

   f2rl_pkg::f2rl_cmd_type cmd;
   f2rl_pkg::f2rl_sts_type sts;

   // result beat that carries an error cause
   logic err_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         highest_addr_ff <= '1;
      end else if (csr_write_enable) begin
         highest_addr_ff <= csr_write_data;
      end
   end

   // sequencer: check, divide pass by pass, then stream limbs out
   f2rl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // datapath: value bytes, divider, limb buffer, packer and result beat
   f2rl_datapath #(
      .MAX_LIMBS        (MAX_LIMBS),
      .LIMBS_PER_RESULT (LIMBS_PER_RESULT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .highest_address     (highest_addr_ff),
      .req_value_w0        (req_value_w0),
      .req_value_w1        (req_value_w1),
      .req_value_w2        (req_value_w2),
      .req_value_w3        (req_value_w3),
      .req_radix           (req_radix),
      .req_limb_count      (req_limb_count),
      .req_bits_mode       (req_bits_mode),
      .req_dest_address    (req_dest_address),
      .rsp_valid           (rsp_valid),
      .rsp_write_address   (rsp_write_address),
      .rsp_limbs_packed    (rsp_limbs_packed),
      .rsp_limb_count_here (rsp_limb_count_here),
      .rsp_bit_tagged      (rsp_bit_tagged),
      .rsp_error_cause     (rsp_error_cause),
      .rsp_last            (rsp_last)
   );

   assign err_beat = rsp_valid && (rsp_error_cause != f2rl_pkg::ERR_OK);

`include "field_to_radix_limbs_unit_assert.svh"

   // a flagged beat is the only one of its request and carries no limbs
   `F2RL_ASSERT_NOW(a_err_single, err_beat, rsp_last && (rsp_limb_count_here == 4'd0))
   // an accepted request keeps the block busy on the next cycle
   `F2RL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // more beats follow a non-final one, so the sequencer is still working
   `F2RL_ASSERT_NOW(a_more_busy, rsp_valid && !rsp_last, busy)
   // a data beat never carries more limbs than one packed write holds
   `F2RL_ASSERT_NOW(a_beat_size, rsp_valid, rsp_limb_count_here <= 4'(LIMBS_PER_RESULT))

endmodule

`default_nettype wire
